/* sv/lru_column_cache_manager_top_assert.svh */
// Assertion macros for the LRU column cache manager checker.
// Both macros sample on the rising edge of clk and are disabled during reset.
`ifndef LRU_COLUMN_CACHE_MANAGER_TOP_ASSERT_SVH
`define LRU_COLUMN_CACHE_MANAGER_TOP_ASSERT_SVH

// Same-cycle implication.
`define LRUC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LRUC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lruc_pkg.sv */
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared types and codes of the LRU column cache manager.
// ----------------------------------------------------------------------------
package lruc_pkg;

    localparam logic       CMD_GET  = 1'b0;
    localparam logic       CMD_SWAP = 1'b1;

    localparam logic [1:0] KIND_GET_DONE  = 2'd0;
    localparam logic [1:0] KIND_EVICTED   = 2'd1;
    localparam logic [1:0] KIND_SWAP_ELEM = 2'd2;
    localparam logic [1:0] KIND_SWAP_DONE = 2'd3;

    localparam logic [23:0] BUDGET_RESET = 24'd65536;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_GET_ERR,
        OP_GET_BEGIN,
        OP_EVICT,
        OP_GROW,
        OP_GET_END,
        OP_SWAP_BAD,
        OP_UNLINK_A,
        OP_UNLINK_B,
        OP_XCH,
        OP_APPEND_A,
        OP_APPEND_B,
        OP_WALK_INIT,
        OP_WALK_STEP,
        OP_SWAP_END
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic a_oor;
        logic b_oor;
        logic ab_eq;
        logic grow;
        logic short_free;
        logic list_empty;
        logic walk_end;
    } dp_status_t;

endpackage

/* sv/lruc_ctrl.sv */
// ----------------------------------------------------------------------------
// lruc_ctrl
// Sequencer that steps the datapath through a get or a swap transaction.
// ----------------------------------------------------------------------------
module lruc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 cmd,
    input  lruc_pkg::dp_status_t status,
    output lruc_pkg::dp_cmd_t    dp_cmd,
    output logic                 busy
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_G_BEGIN,
        ST_G_EVICT,
        ST_G_END,
        ST_S_BEGIN,
        ST_S_UNB,
        ST_S_XCH,
        ST_S_APA,
        ST_S_APB,
        ST_S_WINIT,
        ST_S_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        dp_cmd.op  = lruc_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    dp_cmd.op  = lruc_pkg::OP_LOAD;
                    state_next = (cmd == lruc_pkg::CMD_SWAP) ? ST_S_BEGIN : ST_G_BEGIN;
                end
            end
            ST_G_BEGIN:
            begin
                if (status.a_oor)
                begin
                    dp_cmd.op  = lruc_pkg::OP_GET_ERR;
                    state_next = ST_IDLE;
                end
                else
                begin
                    dp_cmd.op  = lruc_pkg::OP_GET_BEGIN;
                    state_next = ST_G_EVICT;
                end
            end
            ST_G_EVICT:
            begin
                // evict from the least-recent end until the growth fits or the list is empty
                if (status.grow && status.short_free && !status.list_empty)
                begin
                    dp_cmd.op = lruc_pkg::OP_EVICT;
                end
                else
                begin
                    dp_cmd.op  = lruc_pkg::OP_GROW;
                    state_next = ST_G_END;
                end
            end
            ST_G_END:
            begin
                dp_cmd.op  = lruc_pkg::OP_GET_END;
                state_next = ST_IDLE;
            end
            ST_S_BEGIN:
            begin
                if (status.a_oor || status.b_oor || status.ab_eq)
                begin
                    dp_cmd.op  = lruc_pkg::OP_SWAP_BAD;
                    state_next = ST_IDLE;
                end
                else
                begin
                    dp_cmd.op  = lruc_pkg::OP_UNLINK_A;
                    state_next = ST_S_UNB;
                end
            end
            ST_S_UNB:
            begin
                dp_cmd.op  = lruc_pkg::OP_UNLINK_B;
                state_next = ST_S_XCH;
            end
            ST_S_XCH:
            begin
                dp_cmd.op  = lruc_pkg::OP_XCH;
                state_next = ST_S_APA;
            end
            ST_S_APA:
            begin
                dp_cmd.op  = lruc_pkg::OP_APPEND_A;
                state_next = ST_S_APB;
            end
            ST_S_APB:
            begin
                dp_cmd.op  = lruc_pkg::OP_APPEND_B;
                state_next = ST_S_WINIT;
            end
            ST_S_WINIT:
            begin
                dp_cmd.op  = lruc_pkg::OP_WALK_INIT;
                state_next = ST_S_WALK;
            end
            ST_S_WALK:
            begin
                if (status.walk_end)
                begin
                    dp_cmd.op  = lruc_pkg::OP_SWAP_END;
                    state_next = ST_IDLE;
                end
                else
                begin
                    dp_cmd.op = lruc_pkg::OP_WALK_STEP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

/* sv/lruc_dpath.sv */
// ----------------------------------------------------------------------------
// lruc_dpath
// Entry lengths, LRU list pointers, free-word count and result register.
// ----------------------------------------------------------------------------
module lruc_dpath #(
    parameter int NUM_ENTRIES = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lruc_pkg::dp_cmd_t    dp_cmd,
    output lruc_pkg::dp_status_t status,
    input  logic                 cmd,
    input  logic [4:0]           entry_a,
    input  logic [4:0]           entry_b,
    input  logic [15:0]          request_len,
    input  logic                 budget_we,
    input  logic [23:0]          budget_wdata,
    output logic                 result_valid,
    output logic [1:0]           kind,
    output logic [4:0]           entry,
    output logic [15:0]          filled_len,
    output logic [15:0]          new_len,
    output logic                 error,
    output logic                 last
);

    localparam int PW = $clog2(NUM_ENTRIES + 1);
    localparam int IW = $clog2(NUM_ENTRIES);
    localparam logic [PW-1:0] HEAD = PW'(NUM_ENTRIES);
    localparam logic [6:0]    NUM_W = 7'(NUM_ENTRIES);

    typedef logic [PW-1:0] node_t;

    logic [15:0] len_reg [NUM_ENTRIES];
    node_t       nxt_reg [NUM_ENTRIES];
    node_t       prv_reg [NUM_ENTRIES];
    node_t       head_next_reg;
    node_t       head_prev_reg;
    node_t       walk_reg;
    logic [23:0] free_reg;
    logic [4:0]  a_reg;
    logic [4:0]  b_reg;
    logic [15:0] want_reg;
    logic [15:0] old_reg;
    logic [15:0] la_reg;
    logic [15:0] lb_reg;
    logic        err_reg;

    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [4:0]  entry_reg;
    logic [15:0] filled_reg;
    logic [15:0] newlen_reg;
    logic        error_reg;
    logic        last_reg;

    lruc_pkg::dp_op_t op;
    node_t       node_a;
    node_t       node_b;
    node_t       rd_node;
    logic [15:0] rd_len;
    node_t       rd_nxt;
    node_t       rd_prv;
    logic [15:0] more;
    logic [4:0]  lo;
    logic [4:0]  hi;
    logic        walk_hit;
    logic        walk_drop;
    logic        do_unlink;
    logic        do_append;
    node_t       app_node;

    logic        nw0_en;
    node_t       nw0_addr;
    node_t       nw0_data;
    logic        nw1_en;
    logic        pw0_en;
    node_t       pw0_addr;
    node_t       pw0_data;
    logic        pw1_en;

    assign op     = dp_cmd.op;
    assign node_a = PW'(a_reg);
    assign node_b = PW'(b_reg);
    assign more   = want_reg - old_reg;
    assign lo     = (a_reg < b_reg) ? a_reg : b_reg;
    assign hi     = (a_reg < b_reg) ? b_reg : a_reg;

    always_comb
    begin
        unique case (op)
            lruc_pkg::OP_UNLINK_B:  rd_node = node_b;
            lruc_pkg::OP_EVICT:     rd_node = head_next_reg;
            lruc_pkg::OP_WALK_STEP: rd_node = walk_reg;
            default:                rd_node = node_a;
        endcase
    end

    assign rd_len    = len_reg[rd_node[IW-1:0]];
    assign rd_nxt    = nxt_reg[rd_node[IW-1:0]];
    assign rd_prv    = prv_reg[rd_node[IW-1:0]];
    assign walk_hit  = rd_len > 16'(lo);
    assign walk_drop = walk_hit && !(rd_len > 16'(hi));

    always_comb
    begin
        do_unlink = 1'b0;
        do_append = 1'b0;
        app_node  = node_a;
        unique case (op)
            lruc_pkg::OP_GET_BEGIN,
            lruc_pkg::OP_UNLINK_A,
            lruc_pkg::OP_UNLINK_B:  do_unlink = (rd_len != 16'd0);
            lruc_pkg::OP_EVICT:     do_unlink = 1'b1;
            lruc_pkg::OP_WALK_STEP: do_unlink = walk_drop;
            lruc_pkg::OP_GET_END:   do_append = (rd_len != 16'd0);
            lruc_pkg::OP_APPEND_A:  do_append = (lb_reg != 16'd0);
            lruc_pkg::OP_APPEND_B:
            begin
                do_append = (la_reg != 16'd0);
                app_node  = node_b;
            end
            default:
            begin
                do_unlink = 1'b0;
            end
        endcase
    end

    // Unlink: next[prev]=next, prev[next]=prev.
    // Append: next[n]=HEAD, next[tail]=n, prev[n]=tail, prev[HEAD]=n.
    always_comb
    begin
        nw0_en   = do_unlink || do_append;
        nw0_addr = do_append ? app_node : rd_prv;
        nw0_data = do_append ? HEAD : rd_nxt;
        nw1_en   = do_append;
        pw0_en   = do_unlink || do_append;
        pw0_addr = do_append ? app_node : rd_nxt;
        pw0_data = do_append ? head_prev_reg : rd_prv;
        pw1_en   = do_append;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg      <= lruc_pkg::BUDGET_RESET;
            head_next_reg <= HEAD;
            head_prev_reg <= HEAD;
            valid_reg     <= 1'b0;
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                len_reg[k] <= 16'd0;
            end
        end
        else if (budget_we)
        begin
            free_reg      <= budget_wdata;
            head_next_reg <= HEAD;
            head_prev_reg <= HEAD;
            valid_reg     <= 1'b0;
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                len_reg[k] <= 16'd0;
            end
        end
        else
        begin
            valid_reg <= 1'b0;

            if (nw0_en)
            begin
                if (nw0_addr == HEAD)
                    head_next_reg <= nw0_data;
                else
                    nxt_reg[nw0_addr[IW-1:0]] <= nw0_data;
            end
            if (nw1_en)
            begin
                if (head_prev_reg == HEAD)
                    head_next_reg <= app_node;
                else
                    nxt_reg[head_prev_reg[IW-1:0]] <= app_node;
            end
            if (pw0_en)
            begin
                if (pw0_addr == HEAD)
                    head_prev_reg <= pw0_data;
                else
                    prv_reg[pw0_addr[IW-1:0]] <= pw0_data;
            end
            if (pw1_en)
            begin
                head_prev_reg <= app_node;
            end

            unique case (op)
                lruc_pkg::OP_LOAD:
                begin
                    a_reg    <= entry_a;
                    b_reg    <= (cmd == lruc_pkg::CMD_SWAP) ? entry_b : entry_a;
                    want_reg <= request_len;
                end
                lruc_pkg::OP_GET_ERR:
                begin
                    valid_reg  <= 1'b1;
                    kind_reg   <= lruc_pkg::KIND_GET_DONE;
                    entry_reg  <= a_reg;
                    filled_reg <= 16'd0;
                    newlen_reg <= 16'd0;
                    error_reg  <= 1'b1;
                    last_reg   <= 1'b1;
                end
                lruc_pkg::OP_GET_BEGIN:
                begin
                    old_reg <= rd_len;
                    err_reg <= 1'b0;
                end
                lruc_pkg::OP_EVICT:
                begin
                    len_reg[rd_node[IW-1:0]] <= 16'd0;
                    free_reg   <= free_reg + 24'(rd_len);
                    valid_reg  <= 1'b1;
                    kind_reg   <= lruc_pkg::KIND_EVICTED;
                    entry_reg  <= 5'(rd_node);
                    filled_reg <= 16'd0;
                    newlen_reg <= rd_len;
                    error_reg  <= 1'b0;
                    last_reg   <= 1'b0;
                end
                lruc_pkg::OP_GROW:
                begin
                    if (want_reg > old_reg)
                    begin
                        if (free_reg < 24'(more))
                        begin
                            err_reg <= 1'b1;
                        end
                        else
                        begin
                            free_reg <= free_reg - 24'(more);
                            len_reg[node_a[IW-1:0]] <= want_reg;
                        end
                    end
                end
                lruc_pkg::OP_GET_END:
                begin
                    valid_reg  <= 1'b1;
                    kind_reg   <= lruc_pkg::KIND_GET_DONE;
                    entry_reg  <= a_reg;
                    filled_reg <= (old_reg < want_reg) ? old_reg : want_reg;
                    newlen_reg <= rd_len;
                    error_reg  <= err_reg;
                    last_reg   <= 1'b1;
                end
                lruc_pkg::OP_SWAP_BAD:
                begin
                    valid_reg  <= 1'b1;
                    kind_reg   <= lruc_pkg::KIND_SWAP_DONE;
                    entry_reg  <= a_reg;
                    filled_reg <= 16'd0;
                    newlen_reg <= 16'd0;
                    error_reg  <= status.a_oor || status.b_oor;
                    last_reg   <= 1'b1;
                end
                lruc_pkg::OP_UNLINK_A:
                begin
                    la_reg <= rd_len;
                end
                lruc_pkg::OP_UNLINK_B:
                begin
                    lb_reg <= rd_len;
                end
                lruc_pkg::OP_XCH:
                begin
                    len_reg[node_a[IW-1:0]] <= lb_reg;
                    len_reg[node_b[IW-1:0]] <= la_reg;
                end
                lruc_pkg::OP_WALK_INIT:
                begin
                    walk_reg <= head_next_reg;
                end
                lruc_pkg::OP_WALK_STEP:
                begin
                    walk_reg <= rd_nxt;
                    if (walk_hit)
                    begin
                        valid_reg  <= 1'b1;
                        entry_reg  <= 5'(rd_node);
                        filled_reg <= 16'd0;
                        newlen_reg <= rd_len;
                        error_reg  <= 1'b0;
                        last_reg   <= 1'b0;
                        if (walk_drop)
                        begin
                            kind_reg <= lruc_pkg::KIND_EVICTED;
                            len_reg[rd_node[IW-1:0]] <= 16'd0;
                            free_reg <= free_reg + 24'(rd_len);
                        end
                        else
                        begin
                            kind_reg <= lruc_pkg::KIND_SWAP_ELEM;
                        end
                    end
                end
                lruc_pkg::OP_SWAP_END:
                begin
                    valid_reg  <= 1'b1;
                    kind_reg   <= lruc_pkg::KIND_SWAP_DONE;
                    entry_reg  <= a_reg;
                    filled_reg <= 16'd0;
                    newlen_reg <= 16'd0;
                    error_reg  <= 1'b0;
                    last_reg   <= 1'b1;
                end
                default:
                begin
                    valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign status.a_oor      = {2'b00, a_reg} >= NUM_W;
    assign status.b_oor      = {2'b00, b_reg} >= NUM_W;
    assign status.ab_eq      = (a_reg == b_reg);
    assign status.grow       = (want_reg > old_reg);
    assign status.short_free = (free_reg < 24'(more));
    assign status.list_empty = (head_next_reg == HEAD);
    assign status.walk_end   = (walk_reg == HEAD);

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign entry        = entry_reg;
    assign filled_len   = filled_reg;
    assign new_len      = newlen_reg;
    assign error        = error_reg;
    assign last         = last_reg;

endmodule

/* sv/lru_column_cache_manager_top.sv */
// ----------------------------------------------------------------------------
// lru_column_cache_manager_top
// LRU bookkeeping for variable-length columns sharing a word budget.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to issue a transaction (get or swap); the
// fields are sampled on that edge. Results come out one per cycle at most,
// each flagged by result_valid for exactly one cycle, and the receiver cannot
// stall them: capture every result_valid cycle. The final result of a
// transaction has last set, and busy drops in that same cycle, so the next
// start may be taken right then. A get evicts entries one at a time before
// its result, and a swap walks every entry in the LRU list; an out-of-range
// get or a bad swap skips those steps. The walk follows one list pointer per
// cycle through the single read port of the pointer arrays. Writing budget_we
// empties the cache and loads the new budget as free words; write it only
// while busy is low and no result is pending.
module lru_column_cache_manager_top #(
    parameter int NUM_ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [4:0]  entry_a,
    input  logic [4:0]  entry_b,
    input  logic [15:0] request_len,
    input  logic        budget_we,
    input  logic [23:0] budget_wdata,
    output logic        result_valid,
    output logic [1:0]  kind,
    output logic [4:0]  entry,
    output logic [15:0] filled_len,
    output logic [15:0] new_len,
    output logic        error,
    output logic        last
);

    lruc_pkg::dp_cmd_t    dp_cmd;
    lruc_pkg::dp_status_t dp_status;

    // Sequence each transaction; one datapath step per cycle.
    lruc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .status (dp_status),
        .dp_cmd (dp_cmd),
        .busy   (busy)
    );

    // Hold lengths, list links, free words; drive the result register.
    lruc_dpath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .status       (dp_status),
        .cmd          (cmd),
        .entry_a      (entry_a),
        .entry_b      (entry_b),
        .request_len  (request_len),
        .budget_we    (budget_we),
        .budget_wdata (budget_wdata),
        .result_valid (result_valid),
        .kind         (kind),
        .entry        (entry),
        .filled_len   (filled_len),
        .new_len      (new_len),
        .error        (error),
        .last         (last)
    );

endmodule

/* sv/lruc_checker.sv */
// ----------------------------------------------------------------------------
// lruc_checker
// Port-level checks of the LRU column cache manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru_column_cache_manager_top_assert.svh"

module lruc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_valid,
    input logic [1:0] kind,
    input logic       last
);

    logic done_kind;

    assign done_kind = (kind == lruc_pkg::KIND_GET_DONE) ||
                       (kind == lruc_pkg::KIND_SWAP_DONE);

    `LRUC_ASSERT_NEXT(a_start_busy, start && !busy, busy, "busy not raised after start")
    `LRUC_ASSERT_NOW(a_last_idle, result_valid && last, !busy, "busy held after last result")
    `LRUC_ASSERT_NOW(a_mid_busy, result_valid && !last, busy, "busy dropped mid transaction")
    `LRUC_ASSERT_NOW(a_done_last, result_valid && done_kind, last, "done result without last")

endmodule

bind lru_column_cache_manager_top lruc_checker u_lruc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .kind         (kind),
    .last         (last)
);

/* test/tb_lru_column_cache_manager_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_column_cache_manager_top
// Self-checking bench for the LRU column cache manager: drives get and swap
// transactions, tracks entry lengths, the LRU order and the free words in a
// local model, and compares every result field against that model.
// ----------------------------------------------------------------------------
module tb_lru_column_cache_manager_top;

    localparam int N_ENTRIES   = 32;
    localparam int LIST_HEAD   = N_ENTRIES;   // sentinel slot of the LRU ring
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0]  kind;
        logic [4:0]  entry;
        logic [15:0] filled;
        logic [15:0] nlen;
        logic        err;
        logic        last;
    } cache_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [4:0]  entry_a;
    logic [4:0]  entry_b;
    logic [15:0] request_len;
    logic        budget_we;
    logic [23:0] budget_wdata;
    logic        result_valid;
    logic [1:0]  kind;
    logic [4:0]  entry;
    logic [15:0] filled_len;
    logic [15:0] new_len;
    logic        error;
    logic        last;

    // Model state: column lengths, LRU ring (head = least recent), free words.
    cache_result_t pending_results[$];
    int unsigned   col_len[N_ENTRIES];
    int unsigned   lru_nx[N_ENTRIES + 1];
    int unsigned   lru_pv[N_ENTRIES + 1];
    int unsigned   free_words;
    int unsigned   budget;

    int unsigned   send_idle_pct;
    int unsigned   cycle_count;
    int unsigned   fail_count;

    lru_column_cache_manager_top #(
        .NUM_ENTRIES (N_ENTRIES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .entry_a      (entry_a),
        .entry_b      (entry_b),
        .request_len  (request_len),
        .budget_we    (budget_we),
        .budget_wdata (budget_wdata),
        .result_valid (result_valid),
        .kind         (kind),
        .entry        (entry),
        .filled_len   (filled_len),
        .new_len      (new_len),
        .error        (error),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Cache model
    // ------------------------------------------------------------------------
    task automatic clear_cache();
        for (int k = 0; k <= N_ENTRIES; k++)
        begin
            if (k < N_ENTRIES)
                col_len[k] = 0;
            lru_nx[k] = LIST_HEAD;
            lru_pv[k] = LIST_HEAD;
        end
        free_words = budget;
    endtask

    task automatic unlink_col(int unsigned n);
        lru_nx[lru_pv[n]] = lru_nx[n];
        lru_pv[lru_nx[n]] = lru_pv[n];
    endtask

    // Append at the most recent end of the ring.
    task automatic append_col(int unsigned n);
        int unsigned p;
        p = lru_pv[LIST_HEAD];
        lru_nx[n] = LIST_HEAD;
        lru_pv[n] = p;
        lru_nx[p] = n;
        lru_pv[LIST_HEAD] = n;
    endtask

    task automatic post_result(logic [1:0] k, int unsigned e, int unsigned f,
                               int unsigned l, logic err);
        cache_result_t r;
        r.kind   = k;
        r.entry  = e[4:0];
        r.filled = f[15:0];
        r.nlen   = l[15:0];
        r.err    = err;
        r.last   = 1'b0;
        pending_results.push_back(r);
    endtask

    task automatic drop_col(int unsigned n);
        int unsigned freed;
        freed = col_len[n];
        unlink_col(n);
        free_words = (free_words + freed) & 24'hFFFFFF;
        col_len[n] = 0;
        post_result(lruc_pkg::KIND_EVICTED, n, 0, freed, 1'b0);
    endtask

    task automatic predict_transaction(logic c, int unsigned a, int unsigned b,
                                       int unsigned want);
        int unsigned old_len;
        int unsigned more;
        int unsigned lo;
        int unsigned hi;
        int unsigned t;
        int unsigned n;
        int unsigned nx;
        logic        err;
        err = 1'b0;
        if (c == lruc_pkg::CMD_GET)
        begin
            old_len = col_len[a];
            if (old_len != 0)
                unlink_col(a);
            if (want > old_len)
            begin
                more = want - old_len;
                while (free_words < more && lru_nx[LIST_HEAD] != LIST_HEAD)
                    drop_col(lru_nx[LIST_HEAD]);
                if (free_words < more)
                    err = 1'b1;
                else
                begin
                    free_words -= more;
                    col_len[a] = want;
                end
            end
            if (col_len[a] != 0)
                append_col(a);
            post_result(lruc_pkg::KIND_GET_DONE, a, (old_len < want) ? old_len : want,
                        col_len[a], err);
        end
        else if (a == b)
            post_result(lruc_pkg::KIND_SWAP_DONE, a, 0, 0, 1'b0);
        else
        begin
            if (col_len[a] != 0)
                unlink_col(a);
            if (col_len[b] != 0)
                unlink_col(b);
            t = col_len[a];
            col_len[a] = col_len[b];
            col_len[b] = t;
            if (col_len[a] != 0)
                append_col(a);
            if (col_len[b] != 0)
                append_col(b);
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            // Walk least to most recent: swap elements or drop short columns.
            n = lru_nx[LIST_HEAD];
            while (n != LIST_HEAD)
            begin
                nx = lru_nx[n];
                if (col_len[n] > lo)
                begin
                    if (col_len[n] > hi)
                        post_result(lruc_pkg::KIND_SWAP_ELEM, n, 0, col_len[n], 1'b0);
                    else
                        drop_col(n);
                end
                n = nx;
            end
            post_result(lruc_pkg::KIND_SWAP_DONE, a, 0, 0, 1'b0);
        end
        t = pending_results.size() - 1;
        pending_results[t].last = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Drive and check
    // ------------------------------------------------------------------------

    // Leave start high on return so back-to-back transactions need no
    // second assignment in the same step; busy must rise right after accept.
    // Idle the sender one cycle at a time with the configured odds.
    task automatic send_transaction(logic c, int unsigned a, int unsigned b,
                                    int unsigned want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        cmd         <= c;
        entry_a     <= a[4:0];
        entry_b     <= b[4:0];
        request_len <= want[15:0];
        do
            @(posedge clk);
        while (busy);
        predict_transaction(c, a, b, want);
    endtask

    // Hold start low and wait until every expected result has arrived.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_budget(int unsigned value);
        drain();
        budget_we    <= 1'b1;
        budget_wdata <= value[23:0];
        @(posedge clk);
        budget_we    <= 1'b0;
        budget = value & 24'hFFFFFF;
        clear_cache();
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cache_result_t exp_r;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d entry %0d", kind, entry);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (kind !== exp_r.kind)
                begin
                    $error("kind: expected %0d, got %0d", exp_r.kind, kind);
                    fail_count++;
                end
                if (entry !== exp_r.entry)
                begin
                    $error("entry: expected %0d, got %0d", exp_r.entry, entry);
                    fail_count++;
                end
                if (filled_len !== exp_r.filled)
                begin
                    $error("filled_len: expected %0d, got %0d", exp_r.filled, filled_len);
                    fail_count++;
                end
                if (new_len !== exp_r.nlen)
                begin
                    $error("new_len: expected %0d, got %0d", exp_r.nlen, new_len);
                    fail_count++;
                end
                if (error !== exp_r.err)
                begin
                    $error("error: expected %0d, got %0d", exp_r.err, error);
                    fail_count++;
                end
                if (last !== exp_r.last)
                begin
                    $error("last: expected %0d, got %0d", exp_r.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_lru_column_cache_manager_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, zero length, shrink, growth with eviction, swaps.
    task automatic test_directed();
        send_transaction(lruc_pkg::CMD_GET, 0, 31, 0);          // zero length stays out
        send_transaction(lruc_pkg::CMD_GET, 31, 0, 65535);
        send_transaction(lruc_pkg::CMD_GET, 5, 0, 10);          // evicts entry 31
        send_transaction(lruc_pkg::CMD_GET, 5, 0, 3);           // never shrinks
        send_transaction(lruc_pkg::CMD_GET, 2, 0, 20);
        send_transaction(lruc_pkg::CMD_GET, 9, 0, 7);
        send_transaction(lruc_pkg::CMD_GET, 30, 0, 40);
        send_transaction(lruc_pkg::CMD_GET, 5, 0, 12);          // grows in place
        send_transaction(lruc_pkg::CMD_SWAP, 5, 5, 0);          // equal indices
        send_transaction(lruc_pkg::CMD_SWAP, 2, 9, 0);          // walk: swap and drop
        send_transaction(lruc_pkg::CMD_SWAP, 0, 31, 0);
        send_transaction(lruc_pkg::CMD_SWAP, 31, 0, 0);
        send_transaction(lruc_pkg::CMD_GET, 17, 21, 65535);
        send_transaction(lruc_pkg::CMD_SWAP, 17, 30, 0);
    endtask

    // Budget extremes and a budget that cannot be met.
    task automatic test_budget_limits();
        write_budget(100);
        send_transaction(lruc_pkg::CMD_GET, 1, 0, 60);
        send_transaction(lruc_pkg::CMD_GET, 3, 0, 30);
        send_transaction(lruc_pkg::CMD_GET, 4, 0, 200);         // evicts all, still short
        send_transaction(lruc_pkg::CMD_GET, 4, 0, 100);
        write_budget(0);
        send_transaction(lruc_pkg::CMD_GET, 0, 0, 1);
        send_transaction(lruc_pkg::CMD_GET, 0, 0, 0);
        send_transaction(lruc_pkg::CMD_SWAP, 0, 1, 0);
        write_budget(24'hFFFFFF);
        send_transaction(lruc_pkg::CMD_GET, 10, 0, 65535);
        send_transaction(lruc_pkg::CMD_GET, 11, 0, 65535);
        send_transaction(lruc_pkg::CMD_SWAP, 10, 11, 0);
    endtask

    // Mostly short columns so swaps reach past the indices and gets evict.
    task automatic test_random(int unsigned count);
        int unsigned r;
        int unsigned want;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 5)
                want = $urandom_range(65535);
            else if (r < 15)
                want = $urandom_range(0, 400);
            else
                want = $urandom_range(0, 48);
            if ($urandom_range(99) < 22)
                send_transaction(lruc_pkg::CMD_SWAP, $urandom_range(31),
                                 $urandom_range(31), want);
            else
                send_transaction(lruc_pkg::CMD_GET, $urandom_range(31),
                                 $urandom_range(31), want);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        cmd           = lruc_pkg::CMD_GET;
        entry_a       = '0;
        entry_b       = '0;
        request_len   = '0;
        budget_we     = 1'b0;
        budget_wdata  = '0;
        cycle_count   = 0;
        fail_count    = 0;
        send_idle_pct = 19;
        budget        = lruc_pkg::BUDGET_RESET;
        clear_cache();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_budget_limits();

        write_budget(300);
        test_random(90);

        send_idle_pct = 62;
        write_budget(1000);
        test_random(80);

        send_idle_pct = 0;
        write_budget(150);
        test_random(80);

        drain();
        if (fail_count == 0)
            $display("tb_lru_column_cache_manager_top OK");
        else
            $display("tb_lru_column_cache_manager_top NOT OK");
        $finish;
    end

endmodule
